@@ rtl/trf_pkg.sv @@
// Package for the trajectory record filter: word sizes, register indexes,
// operand-select codes and the structs between the top, controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trf_pkg;

    localparam int W = 48;                    // word bits
    localparam int F = 16;                    // fraction bits
    localparam int NFIELD = 8;                // time, pos x/y/z, vel x/y/z, sound speed
    localparam int S_DATA_BITS = ((NFIELD * W - 1 + 7) / 8) * 8;
    localparam int M_DATA_BITS = S_DATA_BITS;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;

    // register indexes (byte address / 8)
    localparam logic [2:0] REG_FLAG_FILTER = 3'd0;
    localparam logic [2:0] REG_RANGE_STEP  = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_TAN_LOOK    = 3'd3;
    localparam logic [2:0] REG_INIT_SEEN   = 3'd4;

    // item kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // arithmetic operand selects
    localparam logic [2:0] SEL_NONE = 3'd0;
    localparam logic [2:0] SEL_ZERO = 3'd1;
    localparam logic [2:0] SEL_SQ   = 3'd2;
    localparam logic [2:0] SEL_RDIV = 3'd3;
    localparam logic [2:0] SEL_IMUL = 3'd4;
    localparam logic [2:0] SEL_IDIV = 3'd5;

    typedef struct packed {
        logic [3:0]   flag_filter;
        logic [W-2:0] range_step;
        logic [W-1:0] time_step;
        logic [W-1:0] tan_look;
        logic [1:0]   init_seen;
    } t_cfg;

    // field 0 time, 1..3 position, 4..6 velocity, 7 sound speed (top bit zero)
    typedef struct packed {
        logic                     op;
        logic [NFIELD-1:0][W-1:0] f;
    } t_item;

    typedef struct packed {
        logic                     valid;
        logic                     rec_valid;
        logic [3:0]               flags;
        logic [NFIELD-1:0][W-1:0] f;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [2:0] sel;
        logic [2:0] idx;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic range_hit;
        logic need_div;
        logic need_interp;
        logic arith_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/trajectory_record_filter_core.sv @@
// Trajectory record filter, top level: stream ports, register port,
// controller and datapath. Uses trf_pkg, trf_ctrl and trf_datapath.
// A start item passes only the dispatch and done states before the output register;
// a sample takes longer, most with an interpolated range record, as it runs through the
// shared bit-serial unit (shift-add multiply, restoring divide).
// One item at a time, next one taken the cycle after commit; commit holds while the
// previous result waits. Reset: synchronous active low, clears config, state, handshakes.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_record_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata, low bit up: sample_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // speed_of_sound, zero pad
    input  logic [trf_pkg::S_DATA_BITS-1:0]     i_s_tdata,
    // tuser: op
    input  logic                                i_s_tuser,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata, low bit up: rec_time, rec_pos_x/y/z, rec_vel_x/y/z, rec_speed_of_sound,
    // zero pad
    output logic [trf_pkg::M_DATA_BITS-1:0]     o_m_tdata,
    // tuser, low bit up: record_valid, flags[3:0]
    output logic [4:0]                          o_m_tuser,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [trf_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [trf_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [trf_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import trf_pkg::*;

    // config registers; the user must write them only while idle; no check in the block
    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FLAG_FILTER: r_cfg.flag_filter <= pwdata[3:0];
                REG_RANGE_STEP:  r_cfg.range_step  <= pwdata[W-2:0];
                REG_TIME_STEP:   r_cfg.time_step   <= pwdata[W-1:0];
                REG_TAN_LOOK:    r_cfg.tan_look    <= pwdata[W-1:0];
                REG_INIT_SEEN:   r_cfg.init_seen   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_FLAG_FILTER: prdata = CFG_DATA_BITS'(r_cfg.flag_filter);
            REG_RANGE_STEP:  prdata = CFG_DATA_BITS'(r_cfg.range_step);
            REG_TIME_STEP:   prdata = CFG_DATA_BITS'(r_cfg.time_step);
            REG_TAN_LOOK:    prdata = CFG_DATA_BITS'(r_cfg.tan_look);
            REG_INIT_SEEN:   prdata = CFG_DATA_BITS'(r_cfg.init_seen);
            default:         prdata = '0;
        endcase
    end

    // unpack the incoming transaction; the sound speed field gets a zero top bit
    t_item item;

    always_comb begin
        item.op = i_s_tuser;
        for (int i = 0; i < NFIELD - 1; i++) begin
            item.f[i] = i_s_tdata[i*W +: W];
        end
        item.f[NFIELD-1] = {1'b0, i_s_tdata[(NFIELD-1)*W +: W-1]};
    end

    t_dp_cmd    cmd;
    t_dp_status status;
    t_out       res;

    trf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath holds the result in its output register until the master side takes it
    trf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (item),
        .i_cmd       (cmd),
        .i_out_ready (i_m_tready),
        .o_status    (status),
        .o_out       (res)
    );

    // pack the result transaction
    always_comb begin
        o_m_tdata = '0;
        for (int i = 0; i < NFIELD - 1; i++) begin
            o_m_tdata[i*W +: W] = res.f[i];
        end
        o_m_tdata[(NFIELD-1)*W +: W-1] = res.f[NFIELD-1][W-2:0];
    end

    assign o_m_tvalid = res.valid;
    assign o_m_tuser  = {res.flags, res.rec_valid};

    // a result never appears the cycle right after its item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after input transaction");

    // results are committed only while the input side is closed
    a_commit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result committed while input side was open");

    // no record means every record field is cleared
    a_empty_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("record fields nonzero without a record");

    // zero up and zero down never fire on the same sample
    a_zero_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[1] && o_m_tuser[2]))
        else $error("zero up and zero down raised together");

endmodule

`default_nettype wire

@@ rtl/trf_arith.sv @@
// Shared bit-serial unit: shift-add multiply (W steps) and restoring divide
// (2W steps, quotient and remainder). Depends on trf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trf_arith (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_div,
    input  logic [trf_pkg::W-1:0]     i_a,
    input  logic [trf_pkg::W-1:0]     i_b,
    input  logic [2*trf_pkg::W-1:0]   i_num,
    input  logic [trf_pkg::W-1:0]     i_den,
    output logic                      o_done,
    output logic [2*trf_pkg::W-1:0]   o_res,
    output logic [trf_pkg::W-1:0]     o_rem
);
    import trf_pkg::*;

    localparam int CW = $clog2(2 * W + 1);

    logic          r_busy;
    logic          r_div;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [2*W-1:0] r_work;
    logic [W-1:0]  r_mpl;
    logic [W-1:0]  r_den;
    logic [2*W-1:0] r_res;
    logic [W:0]    r_rem;

    logic [W:0] trial;
    logic       fits;

    assign trial = {r_rem[W-1:0], r_work[2*W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_div  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_div  <= i_div;
                r_res  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_mpl  <= i_b;
                if (i_div) begin
                    r_work <= i_num;
                    r_cnt  <= CW'(2 * W);
                end else begin
                    r_work <= {{W{1'b0}}, i_a};
                    r_cnt  <= CW'(W);
                end
            end else if (r_busy) begin
                if (r_div) begin
                    // one quotient bit per step
                    r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                    r_res <= {r_res[2*W-2:0], fits};
                end else begin
                    if (r_mpl[0]) begin
                        r_res <= r_res + r_work;
                    end
                    r_mpl <= r_mpl >> 1;
                end
                r_work <= r_work << 1;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_rem  = r_rem[W-1:0];

endmodule

`default_nettype wire

@@ rtl/trf_datapath.sv @@
// Datapath: filter state, latched item, flag logic, interpolation with
// saturation and the output register. Uses trf_pkg and trf_arith.
`timescale 1ns / 1ps
`default_nettype none

module trf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trf_pkg::t_cfg       i_cfg,
    input  trf_pkg::t_item      i_item,
    input  trf_pkg::t_dp_cmd    i_cmd,
    input  logic                i_out_ready,
    output trf_pkg::t_dp_status o_status,
    output trf_pkg::t_out       o_out
);
    import trf_pkg::*;

    // latched item
    logic                     r_op;
    logic [NFIELD-1:0][W-1:0] r_cur;

    // filter state
    logic [W-1:0]             r_next_mark;
    logic [W-1:0]             r_last_time;
    logic [NFIELD-1:0][W-1:0] r_prev;
    logic                     r_prev_sup;
    logic [1:0]               r_seen;

    // arithmetic results
    logic [2*W-1:0]           r_zprod;
    logic [2*W+1:0]           r_sqsum;
    logic [2*W-1:0]           r_csq;
    logic [W-1:0]             r_rem;
    logic [2*W-1:0]           r_prod;
    logic [NFIELD-1:0][W-1:0] r_rec;

    // output register
    t_out r_out;

    // arithmetic unit hookup
    logic           a_div;
    logic [W-1:0]   a_a, a_b, a_den;
    logic [2*W-1:0] a_num;
    logic           a_done;
    logic [2*W-1:0] a_res;
    logic [W-1:0]   a_rem;

    trf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_div   (a_div),
        .i_a     (a_a),
        .i_b     (a_b),
        .i_num   (a_num),
        .i_den   (a_den),
        .o_done  (a_done),
        .o_res   (a_res),
        .o_rem   (a_rem)
    );

    // range mark
    logic signed [W-1:0] x, px, mark, mark_k;
    logic [W:0]          d_full;
    logic [W-1:0]        d, dm1, den_x, nmag;
    logic                range_hit, need_div, need_interp, nneg;

    assign x    = signed'(r_cur[1]);
    assign px   = signed'(r_prev[1]);
    assign mark = signed'(r_next_mark);

    assign range_hit   = (i_cfg.range_step != '0) && (x >= mark);
    assign d_full      = {x[W-1], x} - {mark[W-1], mark};
    assign d           = d_full[W-1:0];
    assign dm1         = d - W'(1);
    assign need_div    = d != '0;
    // mark moves past whole steps already overrun: mark + (d-1) - (d-1) mod step
    assign mark_k      = need_div ? signed'(r_next_mark + dm1 - r_rem) : mark;
    assign need_interp = x > px;
    assign den_x       = r_cur[1] - r_prev[1];
    assign nneg        = mark_k < px;
    assign nmag        = nneg ? (r_prev[1] - mark_k) : (mark_k - r_prev[1]);

    // one field of the interpolation, in order-preserving unsigned form
    logic [W-1:0] f_prev, f_cur, f_hi, dmag, room, ql, sat_b, sat_v;
    logic         is_signed, dneg, q_hi;

    always_comb begin
        is_signed = (i_cmd.idx != 3'd0) && (i_cmd.idx != 3'd7);
        f_prev    = r_prev[i_cmd.idx];
        f_cur     = r_cur[i_cmd.idx];
        if (is_signed) begin
            f_prev[W-1] = ~f_prev[W-1];
            f_cur[W-1]  = ~f_cur[W-1];
        end
        f_hi = (i_cmd.idx == 3'd7) ? {1'b0, {(W-1){1'b1}}} : {W{1'b1}};
        dneg = f_cur < f_prev;
        dmag = dneg ? (f_prev - f_cur) : (f_cur - f_prev);
        q_hi = |a_res[2*W-1:W];
        ql   = a_res[W-1:0];
        room = f_hi - f_prev;
        if (dneg != nneg) begin
            sat_b = (q_hi || (ql > f_prev)) ? '0 : (f_prev - ql);
        end else begin
            sat_b = (q_hi || (ql > room)) ? f_hi : (f_prev + ql);
        end
        sat_v = sat_b;
        if (is_signed) begin
            sat_v[W-1] = ~sat_b[W-1];
        end
    end

    // operand select
    logic [W-1:0] sq_op;

    always_comb begin
        case (i_cmd.idx)
            3'd0:    sq_op = mag_of(r_cur[4]);
            3'd1:    sq_op = mag_of(r_cur[5]);
            3'd2:    sq_op = mag_of(r_cur[6]);
            default: sq_op = r_cur[7];
        endcase
        a_div = 1'b0;
        a_a   = '0;
        a_b   = '0;
        a_num = '0;
        a_den = '0;
        case (i_cmd.sel)
            SEL_ZERO: begin
                a_a = mag_of(r_cur[1]);
                a_b = mag_of(i_cfg.tan_look);
            end
            SEL_SQ: begin
                a_a = sq_op;
                a_b = sq_op;
            end
            SEL_RDIV: begin
                a_div = 1'b1;
                a_num = {{W{1'b0}}, dm1};
                a_den = {1'b0, i_cfg.range_step};
            end
            SEL_IMUL: begin
                a_a = dmag;
                a_b = nmag;
            end
            SEL_IDIV: begin
                a_div = 1'b1;
                a_num = r_prod;
                a_den = den_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_cur <= i_item.f;
        end
        if (a_done) begin
            case (i_cmd.sel)
                SEL_ZERO: r_zprod <= a_res;
                SEL_SQ: begin
                    if (i_cmd.idx == 3'd0) begin
                        r_sqsum <= {2'b00, a_res};
                    end else if (i_cmd.idx == 3'd3) begin
                        r_csq <= a_res;
                    end else begin
                        r_sqsum <= r_sqsum + {2'b00, a_res};
                    end
                end
                SEL_RDIV: r_rem <= a_rem;
                SEL_IMUL: r_prod <= a_res;
                SEL_IDIV: r_rec[i_cmd.idx] <= sat_v;
                default: ;
            endcase
        end
    end

    // flags and next state
    logic signed [2*W:0] y_ref, line_ref;
    logic                above, timed, zup, zdown, sup, mach, have_interp, rec_valid;
    logic [3:0]          flags;
    logic [1:0]          seen_nx;
    logic [W-1:0]        mark_room, mark_nx;

    assign y_ref    = signed'({{(W+1-F){r_cur[2][W-1]}}, r_cur[2], {F{1'b0}}});
    assign line_ref = i_cfg.tan_look[W-1] ? -signed'({1'b0, r_zprod})
                                          : signed'({1'b0, r_zprod});
    assign above    = y_ref >= line_ref;

    always_comb begin
        timed = !range_hit && (i_cfg.time_step != '0) && (r_cur[0] > r_last_time)
                && ((r_cur[0] - r_last_time) > i_cfg.time_step);
        zup     = 1'b0;
        zdown   = 1'b0;
        seen_nx = r_seen;
        if (x > 0) begin
            if (!r_seen[0]) begin
                if (above) begin
                    zup        = 1'b1;
                    seen_nx[0] = 1'b1;
                end
            end else if (!r_seen[1]) begin
                if (!above) begin
                    zdown      = 1'b1;
                    seen_nx[1] = 1'b1;
                end
            end
        end
        sup         = r_sqsum > {2'b00, r_csq};
        mach        = r_prev_sup && !sup;
        flags       = {range_hit || timed, mach, zdown, zup};
        have_interp = range_hit && need_interp;
        rec_valid   = have_interp || ((flags & i_cfg.flag_filter) != 4'd0);
        mark_room   = {1'b0, {(W-1){1'b1}}} - mark_k;
        mark_nx     = ({1'b0, i_cfg.range_step} > mark_room) ? {1'b0, {(W-1){1'b1}}}
                                                            : (mark_k + {1'b0, i_cfg.range_step});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_mark <= '0;
            r_last_time <= '0;
            r_prev      <= '0;
            r_prev_sup  <= 1'b0;
            r_seen      <= 2'b00;
            r_out       <= '0;
        end else begin
            // hold until taken, set on commit
            r_out.valid <= i_cmd.commit || (r_out.valid && !i_out_ready);
            if (i_cmd.commit) begin
                if (r_op == OP_START) begin
                    r_next_mark <= '0;
                    r_last_time <= '0;
                    r_prev_sup  <= 1'b0;
                    r_seen      <= i_cfg.init_seen;
                    r_prev[0]        <= '0;
                    r_prev[NFIELD-1] <= '0;
                    for (int i = 1; i < 7; i++) begin
                        r_prev[i] <= r_cur[i];
                    end
                    r_out.rec_valid <= 1'b0;
                    r_out.flags     <= 4'd0;
                    r_out.f         <= '0;
                end else begin
                    if (range_hit) begin
                        r_next_mark <= mark_nx;
                    end
                    if (range_hit || timed) begin
                        r_last_time <= r_cur[0];
                    end
                    r_prev_sup      <= sup;
                    r_seen          <= seen_nx;
                    r_prev          <= r_cur;
                    r_out.rec_valid <= rec_valid;
                    r_out.flags     <= flags;
                    if (!rec_valid) begin
                        r_out.f <= '0;
                    end else if (have_interp) begin
                        r_out.f <= r_rec;
                    end else begin
                        r_out.f <= r_cur;
                    end
                end
            end
        end
    end

    assign o_out = r_out;

    assign o_status.is_start    = r_op == OP_START;
    assign o_status.range_hit   = range_hit;
    assign o_status.need_div    = need_div;
    assign o_status.need_interp = need_interp;
    assign o_status.arith_done  = a_done;
    assign o_status.out_free    = !r_out.valid || i_out_ready;

endmodule

`default_nettype wire

@@ rtl/trf_ctrl.sv @@
// Controller: sequences one item at a time, a sample through the shared arithmetic
// unit, and commits it. Uses trf_pkg command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module trf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  trf_pkg::t_dp_status i_status,
    output logic                o_s_tready,
    output trf_pkg::t_dp_cmd    o_cmd
);
    import trf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_ZMUL = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_RDIV = 3'd4;
    localparam logic [2:0] S_IMUL = 3'd5;
    localparam logic [2:0] S_IDIV = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_launched, n_launched;
    logic       arith_state;

    assign arith_state = (r_state == S_ZMUL) || (r_state == S_SQ) || (r_state == S_RDIV)
                         || (r_state == S_IMUL) || (r_state == S_IDIV);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_launched = r_launched;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.load = (r_state == S_IDLE) && i_s_tvalid;
        if (arith_state) begin
            if (!r_launched) begin
                o_cmd.start = 1'b1;
                n_launched  = 1'b1;
            end else if (i_status.arith_done) begin
                n_launched = 1'b0;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx   = 3'd0;
                n_state = i_status.is_start ? S_DONE : S_ZMUL;
            end
            S_ZMUL: begin
                o_cmd.sel = SEL_ZERO;
                if (r_launched && i_status.arith_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sel = SEL_SQ;
                if (r_launched && i_status.arith_done) begin
                    if (r_idx != 3'd3) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_idx = 3'd0;
                        if (i_status.range_hit && i_status.need_div) begin
                            n_state = S_RDIV;
                        end else if (i_status.range_hit && i_status.need_interp) begin
                            n_state = S_IMUL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_RDIV: begin
                o_cmd.sel = SEL_RDIV;
                if (r_launched && i_status.arith_done) begin
                    n_state = i_status.need_interp ? S_IMUL : S_DONE;
                end
            end
            S_IMUL: begin
                o_cmd.sel = SEL_IMUL;
                if (r_launched && i_status.arith_done) begin
                    n_state = S_IDIV;
                end
            end
            S_IDIV: begin
                o_cmd.sel = SEL_IDIV;
                if (r_launched && i_status.arith_done) begin
                    if (r_idx == 3'd7) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_IMUL;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= 3'd0;
            r_launched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_launched <= n_launched;
        end
    end

    assign o_s_tready = r_state == S_IDLE;

endmodule

`default_nettype wire
